@@ rtl/core/bpeg_pkg.sv @@
package bpeg_pkg;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_CCW    = 3'd1,
      EV_CW     = 3'd2,
      EV_PRESS  = 3'd3,
      EV_DOUBLE = 3'd4
   } event_code_type;

   // Register index, taken from byte address bit 2.
   localparam logic CSR_LONG_PRESS   = 1'b0;
   localparam logic CSR_DOUBLE_CLICK = 1'b1;

   localparam logic [15:0] LONG_PRESS_RESET   = 16'd1000;
   localparam logic [15:0] DOUBLE_CLICK_RESET = 16'd500;

   typedef struct packed {
      logic [15:0] long_press_ticks;
      logic [15:0] double_click_ticks;
   } cfg_type;

   // Key pin levels, 0 means pressed.
   typedef struct packed {
      logic knob_press_level;
      logic select_key_level;
      logic right_key_level;
      logic left_key_level;
   } keys_type;

   typedef struct packed {
      event_code_type event_code;
      logic           save_request;
      logic           param_reset;
   } result_type;

endpackage

@@ rtl/core/button_press_event_generator_unit.sv @@
// An accepted item is held in the input register and its result is then
// registered in the result register, unless a stall holds it back.
// Throughput: one item per cycle unless rsp_tready stalls a result; the key
// state advances in a single pass from input register to result register.
// While a result waits for rsp_tready, the input register still takes one item.
// Reset is synchronous and active high: it empties both registers, clears
// the hold and window state and loads the register defaults 1000 and 500.
module button_press_event_generator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] left_key_level, [1] right_key_level, [2] select_key_level,
   // [3] knob_press_level, [7:4] zero
   input  logic [7:0]  req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] event_code, [3] save_request, [4] param_reset, [7:5] zero
   output logic [7:0]  rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bpeg_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   keys_type   in_keys_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;
   logic       in_load, out_load;

   bpeg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bpeg_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (out_load),
      .keys   (in_keys_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign out_load   = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | out_load;
   assign in_load    = req_tvalid & req_tready;

   assign in_valid_in  = in_load | (in_valid_ff & ~out_load);
   assign out_valid_in = out_load | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_keys_ff.left_key_level   <= req_tdata[0];
         in_keys_ff.right_key_level  <= req_tdata[1];
         in_keys_ff.select_key_level <= req_tdata[2];
         in_keys_ff.knob_press_level <= req_tdata[3];
      end
      if (out_load) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_data_ff.param_reset, out_data_ff.save_request,
                        out_data_ff.event_code};

   // An item waiting in the input register must not vanish while the result
   // register is blocked.
   a_in_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_load) |=> in_valid_ff)
      else $error("input item dropped while output stalled");

   a_out_filled: assert property (@(posedge clock) disable iff (reset)
      out_load |=> out_valid_ff)
      else $error("result register not valid after load");

   // A save request always comes with a press event, and never with a
   // parameter reset.
   a_save_press: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.save_request) |->
         (out_data_ff.event_code == EV_PRESS && !out_data_ff.param_reset))
      else $error("save request without press event");

endmodule

@@ rtl/core/bpeg_csr.sv @@
module bpeg_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output bpeg_pkg::cfg_type cfg
);
   import bpeg_pkg::*;

   logic [15:0] long_press_ff, long_press_in;
   logic [15:0] double_click_ff, double_click_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      long_press_in   = long_press_ff;
      double_click_in = double_click_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            CSR_LONG_PRESS:   long_press_in   = csr_pwdata[15:0];
            CSR_DOUBLE_CLICK: double_click_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff   <= LONG_PRESS_RESET;
         double_click_ff <= DOUBLE_CLICK_RESET;
      end else begin
         long_press_ff   <= long_press_in;
         double_click_ff <= double_click_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_LONG_PRESS:   csr_prdata = {16'd0, long_press_ff};
         CSR_DOUBLE_CLICK: csr_prdata = {16'd0, double_click_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign cfg.long_press_ticks   = long_press_ff;
   assign cfg.double_click_ticks = double_click_ff;

endmodule

@@ rtl/core/bpeg_core.sv @@
module bpeg_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  bpeg_pkg::keys_type   keys,
   input  bpeg_pkg::cfg_type    cfg,
   output bpeg_pkg::result_type result
);
   import bpeg_pkg::*;

   logic        key_held_ff, key_held_in;
   logic [15:0] hold_count_ff, hold_count_in;
   logic [15:0] click_window_ff, click_window_in;
   logic [15:0] window_mid;
   logic [15:0] hold_inc;
   logic        left, right, sel, knob, any;

   assign left     = ~keys.left_key_level;
   assign right    = ~keys.right_key_level;
   assign sel      = ~keys.select_key_level;
   assign knob     = ~keys.knob_press_level;
   assign any      = left | right | sel | knob;
   assign hold_inc = hold_count_ff + 16'd1;

   always_comb begin
      key_held_in         = key_held_ff;
      hold_count_in       = hold_count_ff;
      window_mid          = click_window_ff;
      result.event_code   = EV_NONE;
      result.save_request = 1'b0;
      result.param_reset  = 1'b0;

      if (!key_held_ff && any) begin
         key_held_in = 1'b1;
         if (left) begin
            result.event_code = EV_CCW;
         end else if (right) begin
            result.event_code = EV_CW;
         end else if (sel) begin
            result.event_code = EV_PRESS;
         end else if (click_window_ff != 16'd0) begin
            result.event_code = EV_DOUBLE;
            window_mid        = 16'd0;
         end else begin
            result.event_code = EV_PRESS;
            window_mid        = cfg.double_click_ticks;
         end
      end else if (key_held_ff) begin
         if (left || right) begin
            hold_count_in = hold_inc;
            if (hold_inc > cfg.long_press_ticks) begin
               result.save_request = 1'b1;
               result.event_code   = EV_PRESS;
            end
         end else if (sel) begin
            hold_count_in = hold_inc;
            if (hold_inc == cfg.long_press_ticks) begin
               result.save_request = 1'b1;
               result.event_code   = EV_PRESS;
            end
         end else if (knob) begin
            hold_count_in = hold_inc;
            result.param_reset = (hold_inc == cfg.long_press_ticks);
         end else begin
            key_held_in   = 1'b0;
            hold_count_in = 16'd0;
         end
      end

      // The window counts down on every tick, including the one that opened it.
      if (window_mid != 16'd0) begin
         click_window_in = window_mid - 16'd1;
      end else begin
         click_window_in = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_held_ff     <= 1'b0;
         hold_count_ff   <= 16'd0;
         click_window_ff <= 16'd0;
      end else if (step) begin
         key_held_ff     <= key_held_in;
         hold_count_ff   <= hold_count_in;
         click_window_ff <= click_window_in;
      end
   end

endmodule

@@ verif/button_press_event_generator_unit_tb.sv @@
`timescale 1ns / 1ps

module button_press_event_generator_unit_tb;
   import bpeg_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [0] left_key_level, [1] right_key_level, [2] select_key_level,
   // [3] knob_press_level, [7:4] zero
   logic [7:0]  req_tdata = 8'h0F;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [2:0] event_code, [3] save_request, [4] param_reset, [7:5] zero
   logic [7:0]  rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   button_press_event_generator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Predictor state and its copy of the registers.
   logic [15:0] long_limit   = LONG_PRESS_RESET;
   logic [15:0] window_limit = DOUBLE_CLICK_RESET;
   logic        key_down     = 1'b0;
   logic [15:0] held_ticks   = '0;
   logic [15:0] window_left  = '0;

   keys_type   pending_scans[$];
   result_type expected_events[$];
   int         queued_scans   = 0;
   int         mismatch_count = 0;
   bit         idling_on      = 1'b1;
   int         req_gap        = 0;
   int         rsp_stall      = 0;

   function automatic void predict_scan(input keys_type keys);
      logic           left, right, sel, knob;
      event_code_type code;
      logic           save, preset;
      left   = !keys.left_key_level;
      right  = !keys.right_key_level;
      sel    = !keys.select_key_level;
      knob   = !keys.knob_press_level;
      code   = EV_NONE;
      save   = 1'b0;
      preset = 1'b0;
      if (!key_down && (left || right || sel || knob)) begin
         key_down = 1'b1;
         if (left) begin
            code = EV_CCW;
         end else if (right) begin
            code = EV_CW;
         end else if (sel) begin
            code = EV_PRESS;
         end else if (window_left != 16'd0) begin
            code = EV_DOUBLE;
            window_left = '0;
         end else begin
            code = EV_PRESS;
            window_left = window_limit;
         end
      end else if (key_down) begin
         // The counted key is picked again on every tick from the current levels.
         if (left || right) begin
            held_ticks = held_ticks + 16'd1;
            if (held_ticks > long_limit) begin
               save = 1'b1;
               code = EV_PRESS;
            end
         end else if (sel) begin
            held_ticks = held_ticks + 16'd1;
            if (held_ticks == long_limit) begin
               save = 1'b1;
               code = EV_PRESS;
            end
         end else if (knob) begin
            held_ticks = held_ticks + 16'd1;
            if (held_ticks == long_limit) preset = 1'b1;
         end else begin
            key_down = 1'b0;
            held_ticks = '0;
         end
      end
      if (window_left != 16'd0) window_left = window_left - 16'd1;
      expected_events.push_back(result_type'{code, save, preset});
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: mismatch: %s", $realtime, what);
   endtask

   task automatic check_result(input logic [7:0] data);
      result_type want;
      if (expected_events.size() == 0) begin
         flag_mismatch($sformatf("unexpected result 0x%02h", data));
      end else begin
         want = expected_events.pop_front();
         if (data[2:0] != want.event_code)
            flag_mismatch($sformatf("event_code expected %0d (%s), got %0d",
               want.event_code, want.event_code.name(), data[2:0]));
         if (data[3] != want.save_request)
            flag_mismatch($sformatf("save_request expected %0b, got %0b",
               want.save_request, data[3]));
         if (data[4] != want.param_reset)
            flag_mismatch($sformatf("param_reset expected %0b, got %0b",
               want.param_reset, data[4]));
      end
   endtask

   // Driver: predicts each item as it is accepted, then offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_scan(keys_type'(req_tdata[3:0]));
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_scans.size() != 0) begin
               req_tdata  <= {4'b0000, pending_scans.pop_front()};
               req_tvalid <= 1'b1;
               if (idling_on && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 15);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result and stalls the result side at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idling_on && $urandom_range(0, 9) == 0) rsp_stall = $urandom_range(1, 15);
         end
      end
   end

   task automatic push_scan(input logic [3:0] levels);
      pending_scans.push_back(keys_type'(levels));
      queued_scans++;
   endtask

   task automatic add_episode();
      int         kind, hold, span, gap;
      logic [3:0] levels;
      kind = $urandom_range(0, 99);
      span = (long_limit <= 16'd40) ? int'(long_limit) + 3 : 12;
      gap  = (window_limit <= 16'd40) ? int'(window_limit) + 2 : 12;
      if (kind < 15) begin
         repeat ($urandom_range(1, 6)) push_scan(4'($urandom()));
      end else if (kind < 40) begin
         // Two knob clicks, with the gap spread around the double-press window.
         repeat ($urandom_range(1, 3)) push_scan(4'h7);
         repeat ($urandom_range(1, gap)) push_scan(4'hF);
         repeat ($urandom_range(1, 3)) push_scan(4'h7);
         push_scan(4'hF);
      end else begin
         levels = 4'($urandom_range(0, 14));
         hold = $urandom_range(1, span);
         for (int i = 0; i < hold; i++) begin
            if (i > 0 && $urandom_range(0, 15) == 0) levels = 4'($urandom_range(0, 14));
            push_scan(levels);
         end
         repeat ($urandom_range(1, 3)) push_scan(4'hF);
      end
   endtask

   task automatic queue_random(input int count);
      int target;
      target = queued_scans + count;
      while (queued_scans < target) add_episode();
   endtask

   task automatic wait_idle();
      while (pending_scans.size() != 0 || req_tvalid || expected_events.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [15:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index == CSR_LONG_PRESS) long_limit = value;
      else window_limit = value;
   endtask

   task automatic run_setting(input logic [15:0] long_value, input logic [15:0] window_value,
                              input int count);
      wait_idle();
      write_csr(CSR_LONG_PRESS, long_value);
      write_csr(CSR_DOUBLE_CLICK, window_value);
      queue_random(count);
   endtask

   initial begin
      static logic [3:0] directed_levels [22] = '{
         4'hF, 4'hE, 4'hE, 4'hF, 4'hD, 4'hF, 4'hB, 4'hF, 4'h7, 4'hF, 4'h7,
         4'hF, 4'h0, 4'h7, 4'hB, 4'hF, 4'h3, 4'hF, 4'hC, 4'hF, 4'h7, 4'hF};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Single keys, priority among several keys, a knob double press and a
      // held press whose counted key changes, all at the reset settings.
      foreach (directed_levels[i]) push_scan(directed_levels[i]);
      queue_random(100);

      run_setting(16'd0, 16'd0, 90);
      run_setting(16'd1, 16'd1, 90);
      run_setting(16'd65535, 16'd65535, 80);
      run_setting(16'd2, 16'd3, 90);
      run_setting(16'($urandom_range(0, 20)), 16'($urandom_range(0, 30)), 90);
      run_setting(16'd12, 16'd40, 90);

      // The last part of the run goes without idling on either side.
      wait_idle();
      idling_on = 1'b0;
      run_setting(16'($urandom_range(0, 20)), 16'($urandom_range(0, 30)), 90);

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** button_press_event_generator_unit: PASSED **");
      end else begin
         $display("** button_press_event_generator_unit: FAILED **");
      end
      $finish;
   end

   initial begin
      #8ms;
      $display("** button_press_event_generator_unit: FAILED **");
      $finish;
   end

endmodule
